[hdl/rsi_pkg.sv]
package rsi_pkg;

  // field and datapath widths
  localparam int unsigned IN_W          = 32;
  localparam int unsigned RAD_W         = 31;
  localparam int unsigned W_W           = 33;
  localparam int unsigned A_W           = 64;
  localparam int unsigned WW_W          = 66;
  localparam int unsigned H_W           = 66;
  localparam int unsigned HM_W          = 65;
  localparam int unsigned R2_W          = 62;
  localparam int unsigned SQ_W          = 130;
  localparam int unsigned LHS_W         = 131;
  localparam int unsigned ROOT_W        = 63;
  localparam int unsigned NUM_W         = 66;
  localparam int unsigned DIV_W         = 96;
  localparam int unsigned Q_W           = 32;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 32;
  localparam int unsigned FRAC_BITS_DEF = 16;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_CENTER_Z = 2'd2,
    REG_RADIUS   = 2'd3
  } cfg_reg_t;

  // one ray
  typedef struct packed {
    logic signed [IN_W-1:0] start_x;
    logic signed [IN_W-1:0] start_y;
    logic signed [IN_W-1:0] start_z;
    logic signed [IN_W-1:0] dir_x;
    logic signed [IN_W-1:0] dir_y;
    logic signed [IN_W-1:0] dir_z;
  } ray_word_t;

  // one result
  typedef struct packed {
    logic            hit;
    logic [Q_W-1:0]  hit_time;
  } res_word_t;

  // side data carried alongside the square root
  typedef struct packed {
    logic            miss;
    logic            hneg;
    logic [HM_W-1:0] hm;
    logic [A_W-1:0]  a;
  } root_tag_t;

endpackage

[hdl/rsi_mul.sv]
module rsi_mul #(
  parameter int unsigned AW = 64,
  parameter int unsigned BW = 64
) (
  input  logic             clk,
  input  logic             en,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] p
);

  localparam int unsigned AL = (AW + 1) / 2;
  localparam int unsigned AH = AW - AL;
  localparam int unsigned BL = (BW + 1) / 2;
  localparam int unsigned BH = BW - BL;
  localparam int unsigned PW = AW + BW;

  logic [AL+BL-1:0] ll;
  logic [AL+BH-1:0] lh;
  logic [AH+BL-1:0] hl;
  logic [AH+BH-1:0] hh;

  // partial products of the split operands
  always_ff @(posedge clk) begin
    if (en) begin
      ll <= (AL+BL)'(a[AL-1:0]) * (AL+BL)'(b[BL-1:0]);
      lh <= (AL+BH)'(a[AL-1:0]) * (AL+BH)'(b[BW-1:BL]);
      hl <= (AH+BL)'(a[AW-1:AL]) * (AH+BL)'(b[BL-1:0]);
      hh <= (AH+BH)'(a[AW-1:AL]) * (AH+BH)'(b[BW-1:BL]);
    end
  end

  // recombine
  always_ff @(posedge clk) begin
    if (en) begin
      p <= PW'(ll) + (PW'(lh) << BL) + (PW'(hl) << AL) + (PW'(hh) << (AL + BL));
    end
  end

endmodule

[hdl/rsi_sqrt.sv]
module rsi_sqrt (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_vld,
  input  logic [rsi_pkg::LHS_W-1:0] disc,
  input  rsi_pkg::root_tag_t       in_tag,
  output logic                     out_vld,
  output logic [rsi_pkg::ROOT_W-1:0] root,
  output rsi_pkg::root_tag_t       out_tag
);
  import rsi_pkg::*;

  logic              vld   [0:ROOT_W];
  logic [LHS_W-1:0]  rem   [0:ROOT_W];
  logic [ROOT_W-1:0] part  [0:ROOT_W];
  root_tag_t         tag   [0:ROOT_W];

  assign vld[0]  = in_vld;
  assign rem[0]  = disc;
  assign part[0] = '0;
  assign tag[0]  = in_tag;

  // one root bit per stage, highest first
  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int unsigned B = ROOT_W - 1 - k;
    logic [LHS_W-1:0] trial;
    logic             fits;

    assign trial = (LHS_W'(part[k]) << (B + 1)) | (LHS_W'(1) << (2 * B));
    assign fits  = rem[k] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= fits ? rem[k] - trial : rem[k];
        part[k+1] <= fits ? (part[k] | (ROOT_W'(1) << B)) : part[k];
        tag[k+1]  <= tag[k];
      end
    end
  end

  assign out_vld = vld[ROOT_W];
  assign root    = part[ROOT_W];
  assign out_tag = tag[ROOT_W];

endmodule

[hdl/rsi_div.sv]
module rsi_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_vld,
  input  logic                      in_miss,
  input  logic [rsi_pkg::DIV_W-1:0] num,
  input  logic [rsi_pkg::A_W-1:0]   a,
  output logic                      out_vld,
  output logic                      out_miss,
  output logic                      out_sat,
  output logic [rsi_pkg::Q_W-1:0]   quo
);
  import rsi_pkg::*;

  logic             vld  [0:Q_W];
  logic             miss [0:Q_W];
  logic             sat  [0:Q_W];
  logic [DIV_W-1:0] rem  [0:Q_W];
  logic [A_W-1:0]   dvs  [0:Q_W];
  logic [Q_W-1:0]   q    [0:Q_W];

  // saturation check against a * 2^32
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      miss[0] <= in_miss;
      sat[0]  <= num >= (DIV_W'(a) << Q_W);
      rem[0]  <= num;
      dvs[0]  <= a;
      q[0]    <= '0;
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    localparam int unsigned B = Q_W - 1 - k;
    logic [DIV_W-1:0] trial;
    logic             fits;

    assign trial = DIV_W'(dvs[k]) << B;
    assign fits  = rem[k] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        miss[k+1] <= miss[k];
        sat[k+1]  <= sat[k];
        dvs[k+1]  <= dvs[k];
        rem[k+1]  <= fits ? rem[k] - trial : rem[k];
        q[k+1]    <= fits ? (q[k] | (Q_W'(1) << B)) : q[k];
      end
    end
  end

  assign out_vld  = vld[Q_W];
  assign out_miss = miss[Q_W];
  assign out_sat  = sat[Q_W];
  assign quo      = q[Q_W];

endmodule

[hdl/ray_sphere_intersection_core.sv]
// Ray against sphere hit time.
// Ray channel: ray_valid / ray_stall / ray carry one ray word (start point and
// direction, signed fixed point). Result channel: res_valid / res_stall / res
// carry the hit flag and the hit time (unsigned fixed point, saturated, zero
// on a miss). A word moves when valid is high and stall is low.
// Sphere centre and radius are written through cfg_we / cfg_idx / cfg_data;
// the user must write them only while no ray is in flight; the block has no check for it.
// Throughput is one ray per cycle while ray_stall is low. From acceptance to
// the result on res a ray passes 8 stages of products, sums and the
// discriminant, one stage per root bit in the 63-stage square root, one
// stage for the numerator, one for the saturation check and one per quotient
// bit in the 32-stage divider, then the output register.
// A skid register behind the output register takes one more word while the
// receiver stalls; once it is full ray_stall rises and the whole pipeline
// holds. Reset clears every valid bit and the sphere registers to zero.
module ray_sphere_intersection_core #(
  parameter int unsigned FRAC_BITS = rsi_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           ray_valid,
  output logic                           ray_stall,
  input  rsi_pkg::ray_word_t             ray,
  output logic                           res_valid,
  input  logic                           res_stall,
  output rsi_pkg::res_word_t             res,
  input  logic                           cfg_we,
  input  logic [rsi_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [rsi_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rsi_pkg::*;

  logic signed [IN_W-1:0] center_x, center_y, center_z;
  logic [RAD_W-1:0]       radius;
  logic [R2_W-1:0]        r2;

  logic en;
  logic skid_vld;
  res_word_t skid;

  // sphere registers
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
      center_z <= '0;
      radius   <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_CENTER_X: center_x <= cfg_data;
        REG_CENTER_Y: center_y <= cfg_data;
        REG_CENTER_Z: center_z <= cfg_data;
        REG_RADIUS:   radius   <= cfg_data[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    r2 <= R2_W'(radius) * R2_W'(radius);
  end

  assign en        = !skid_vld;
  assign ray_stall = skid_vld;

  // stage 1: offset from centre
  logic                   s1_vld;
  logic signed [IN_W-1:0] s1_d [3];
  logic signed [W_W-1:0]  s1_w [3];

  always_ff @(posedge clk) begin
    if (rst) s1_vld <= 1'b0;
    else if (en) s1_vld <= ray_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_d[0] <= ray.dir_x;
      s1_d[1] <= ray.dir_y;
      s1_d[2] <= ray.dir_z;
      s1_w[0] <= W_W'(ray.start_x) - W_W'(center_x);
      s1_w[1] <= W_W'(ray.start_y) - W_W'(center_y);
      s1_w[2] <= W_W'(ray.start_z) - W_W'(center_z);
    end
  end

  // stage 2: per-axis products
  logic                    s2_vld;
  logic [A_W-1:0]          s2_dd [3];
  logic [WW_W-1:0]         s2_ww [3];
  logic signed [HM_W-1:0]  s2_p  [3];
  logic [IN_W-1:0]         dmag  [3];
  logic [W_W-1:0]          wmag  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dmag[i] = s1_d[i][IN_W-1] ? IN_W'(-s1_d[i]) : IN_W'(s1_d[i]);
      wmag[i] = s1_w[i][W_W-1] ? W_W'(-s1_w[i]) : W_W'(s1_w[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s2_vld <= 1'b0;
    else if (en) s2_vld <= s1_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s2_dd[i] <= A_W'(dmag[i]) * A_W'(dmag[i]);
        s2_ww[i] <= WW_W'(wmag[i]) * WW_W'(wmag[i]);
        s2_p[i]  <= HM_W'(s1_d[i]) * HM_W'(s1_w[i]);
      end
    end
  end

  // stage 3: dot products
  logic                  s3_vld;
  logic [A_W-1:0]        s3_a;
  logic [WW_W-1:0]       s3_ww;
  logic signed [H_W-1:0] s3_h;

  always_ff @(posedge clk) begin
    if (rst) s3_vld <= 1'b0;
    else if (en) s3_vld <= s2_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_a  <= s2_dd[0] + s2_dd[1] + s2_dd[2];
      s3_ww <= s2_ww[0] + s2_ww[1] + s2_ww[2];
      s3_h  <= H_W'(s2_p[0]) + H_W'(s2_p[1]) + H_W'(s2_p[2]);
    end
  end

  // stage 4: magnitude of h, zero direction
  logic            s4_vld;
  logic            s4_hneg;
  logic            s4_az;
  logic [HM_W-1:0] s4_hm;
  logic [A_W-1:0]  s4_a;
  logic [WW_W-1:0] s4_ww;

  always_ff @(posedge clk) begin
    if (rst) s4_vld <= 1'b0;
    else if (en) s4_vld <= s3_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_hneg <= s3_h[H_W-1];
      s4_hm   <= s3_h[H_W-1] ? HM_W'(-s3_h) : HM_W'(s3_h);
      s4_az   <= s3_a == '0;
      s4_a    <= s3_a;
      s4_ww   <= s3_ww;
    end
  end

  // stages 5 and 6: wide products
  logic [SQ_W-1:0]        sq;
  logic [A_W+R2_W-1:0]    ar2;
  logic [A_W+WW_W-1:0]    aww;

  rsi_mul #(.AW(HM_W), .BW(HM_W)) u_mul_hh (
    .clk(clk), .en(en), .a(s4_hm), .b(s4_hm), .p(sq)
  );
  rsi_mul #(.AW(A_W), .BW(R2_W)) u_mul_ar (
    .clk(clk), .en(en), .a(s4_a), .b(r2), .p(ar2)
  );
  rsi_mul #(.AW(A_W), .BW(WW_W)) u_mul_aw (
    .clk(clk), .en(en), .a(s4_a), .b(s4_ww), .p(aww)
  );

  logic      s5_vld, s6_vld;
  logic      s5_az, s6_az;
  root_tag_t s5_tag, s6_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_vld <= 1'b0;
      s6_vld <= 1'b0;
    end else if (en) begin
      s5_vld <= s4_vld;
      s6_vld <= s5_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_az  <= s4_az;
      s5_tag <= '{miss: 1'b0, hneg: s4_hneg, hm: s4_hm, a: s4_a};
      s6_az  <= s5_az;
      s6_tag <= s5_tag;
    end
  end

  // stage 7: h^2 + a R^2
  logic              s7_vld;
  logic              s7_az;
  root_tag_t         s7_tag;
  logic [LHS_W-1:0]  s7_lhs;
  logic [SQ_W-1:0]   s7_rhs;

  always_ff @(posedge clk) begin
    if (rst) s7_vld <= 1'b0;
    else if (en) s7_vld <= s6_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_az  <= s6_az;
      s7_tag <= s6_tag;
      s7_lhs <= LHS_W'(sq) + LHS_W'(ar2);
      s7_rhs <= aww;
    end
  end

  // stage 8: discriminant and its sign
  logic             s8_vld;
  root_tag_t        s8_tag;
  logic [LHS_W-1:0] s8_disc;
  logic [LHS_W:0]   disc_diff;

  assign disc_diff = (LHS_W + 1)'(s7_lhs) - (LHS_W + 1)'(s7_rhs);

  always_ff @(posedge clk) begin
    if (rst) s8_vld <= 1'b0;
    else if (en) s8_vld <= s7_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8_tag  <= '{miss: s7_az | disc_diff[LHS_W], hneg: s7_tag.hneg,
                   hm: s7_tag.hm, a: s7_tag.a};
      s8_disc <= disc_diff[LHS_W-1:0];
    end
  end

  // integer square root
  logic              sr_vld;
  logic [ROOT_W-1:0] sr_root;
  root_tag_t         sr_tag;

  rsi_sqrt u_sqrt (
    .clk(clk), .rst(rst), .en(en),
    .in_vld(s8_vld), .disc(s8_disc), .in_tag(s8_tag),
    .out_vld(sr_vld), .root(sr_root), .out_tag(sr_tag)
  );

  // numerator: near root, else far root, else both behind the start
  logic [HM_W+1:0] hm_less_s;
  logic [NUM_W-1:0] hm_plus_s;
  logic [NUM_W-1:0] s_less_hm;
  logic             hm_ge_s;
  logic             s_lt_hm;
  logic [NUM_W-1:0] num_sel;
  logic             num_miss;

  assign hm_less_s = (HM_W + 2)'(sr_tag.hm) - (HM_W + 2)'(sr_root);
  assign hm_plus_s = NUM_W'(sr_tag.hm) + NUM_W'(sr_root);
  assign s_less_hm = NUM_W'(sr_root) - NUM_W'(sr_tag.hm);
  assign hm_ge_s   = !hm_less_s[HM_W+1];
  assign s_lt_hm   = hm_ge_s && (hm_less_s != '0);

  always_comb begin
    if (sr_tag.hneg) begin
      num_sel  = hm_ge_s ? NUM_W'(hm_less_s) : hm_plus_s;
      num_miss = sr_tag.miss;
    end else begin
      num_sel  = s_less_hm;
      num_miss = sr_tag.miss | s_lt_hm;
    end
  end

  logic             s9_vld;
  logic             s9_miss;
  logic [DIV_W-1:0] s9_num;
  logic [A_W-1:0]   s9_a;

  always_ff @(posedge clk) begin
    if (rst) s9_vld <= 1'b0;
    else if (en) s9_vld <= sr_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s9_miss <= num_miss;
      s9_num  <= DIV_W'(num_sel) << FRAC_BITS;
      s9_a    <= sr_tag.a;
    end
  end

  // hit time = numerator / a
  logic           dv_vld, dv_miss, dv_sat;
  logic [Q_W-1:0] dv_quo;

  rsi_div u_div (
    .clk(clk), .rst(rst), .en(en),
    .in_vld(s9_vld), .in_miss(s9_miss), .num(s9_num), .a(s9_a),
    .out_vld(dv_vld), .out_miss(dv_miss), .out_sat(dv_sat), .quo(dv_quo)
  );

  res_word_t res_next;

  always_comb begin
    res_next.hit      = !dv_miss;
    res_next.hit_time = dv_miss ? '0 : (dv_sat ? '1 : dv_quo);
  end

  // output register with skid word behind it
  logic take;
  assign take = res_valid && !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      skid_vld  <= 1'b0;
    end else if (skid_vld) begin
      if (take) begin
        res      <= skid;
        skid_vld <= 1'b0;
      end
    end else if (dv_vld) begin
      if (!res_valid || take) begin
        res       <= res_next;
        res_valid <= 1'b1;
      end else begin
        skid     <= res_next;
        skid_vld <= 1'b1;
      end
    end else if (take) begin
      res_valid <= 1'b0;
    end
  end

  // checks
  a_skid_behind_out: assert property (@(posedge clk) skid_vld |-> res_valid)
    else $error("skid word held without an output word");

  a_miss_zero_time: assert property (@(posedge clk)
    res_valid && !res.hit |-> res.hit_time == '0)
    else $error("miss with a non-zero hit time");

  a_reset_clears: assert property (@(posedge clk) rst |=> !res_valid && !skid_vld)
    else $error("words left after reset");

  a_hold_when_full: assert property (@(posedge clk) disable iff (rst)
    skid_vld |=> $stable(dv_vld) && $stable(dv_quo))
    else $error("pipeline moved while the skid word was full");

endmodule
